### src/tdo_pkg.sv
// Shared types and command codes for the timed digital output block.
// Used by tdo_ctrl, timed_digital_output, pin_checker and tb; no dependencies.
package tdo_pkg;

  localparam int CMD_BITS     = 4;
  localparam int TIME_IN_BITS = 32;

  localparam logic [CMD_BITS-1:0] CMD_TICK    = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_SET     = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_TOGGLE  = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_PULSE   = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_DSET    = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_DCLEAR  = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_DTOGGLE = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_DPULSE  = 4'd8;

  typedef struct packed {
    logic [CMD_BITS-1:0]     command;
    logic [TIME_IN_BITS-1:0] now_time;
    logic [TIME_IN_BITS-1:0] delay_ticks;
    logic [TIME_IN_BITS-1:0] pulse_ticks;
  } cmd_t;

  typedef struct packed {
    logic level;
    logic changed;
  } res_t;

endpackage

### src/tdo_ctrl.sv
// Pin state, timed mode and deadlines; computes one result per request.
// Depends on tdo_pkg.
module tdo_ctrl #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  tdo_pkg::cmd_t item,
  input  logic          cfg_we,
  input  logic          cfg_level,
  output tdo_pkg::res_t result
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_PULSE = 3'd1,
    M_DSET  = 3'd2,
    M_DCLR  = 3'd3,
    M_DTOG  = 3'd4,
    M_DPUL  = 3'd5
  } mode_t;

  logic                 pin_level;
  logic                 pin_level_next;
  mode_t                mode;
  mode_t                mode_next;
  logic [TIME_BITS-1:0] pulse_deadline;
  logic [TIME_BITS-1:0] pulse_deadline_next;
  logic [TIME_BITS-1:0] delay_deadline;
  logic [TIME_BITS-1:0] delay_deadline_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] dly_t;
  logic [TIME_BITS-1:0] pls_t;
  logic [TIME_BITS-1:0] delay_end;
  logic [TIME_BITS-1:0] tick_end;
  logic [TIME_BITS-1:0] tick_diff;
  logic                 reached;

  assign now_t = TIME_BITS'(item.now_time);
  assign dly_t = TIME_BITS'(item.delay_ticks);
  assign pls_t = TIME_BITS'(item.pulse_ticks);

  assign delay_end = now_t + dly_t;
  assign tick_end  = (mode == M_PULSE) ? pulse_deadline : delay_deadline;
  assign tick_diff = now_t - tick_end;
  // wrap-aware: expired when the signed difference is not negative
  assign reached   = ~tick_diff[TIME_BITS-1];

  always_comb begin
    pin_level_next      = pin_level;
    mode_next           = mode;
    pulse_deadline_next = pulse_deadline;
    delay_deadline_next = delay_deadline;
    case (item.command)
      tdo_pkg::CMD_TICK: begin
        if (mode != M_IDLE && reached) begin
          case (mode)
            M_PULSE: begin
              pin_level_next = ~pin_level;
              mode_next      = M_IDLE;
            end
            M_DSET: begin
              pin_level_next = 1'b1;
              mode_next      = M_IDLE;
            end
            M_DCLR: begin
              pin_level_next = 1'b0;
              mode_next      = M_IDLE;
            end
            M_DTOG: begin
              pin_level_next = ~pin_level;
              mode_next      = M_IDLE;
            end
            M_DPUL: begin
              pin_level_next = ~pin_level;
              mode_next      = M_PULSE;
            end
            default: mode_next = M_IDLE;
          endcase
        end
      end
      tdo_pkg::CMD_SET: begin
        pin_level_next = 1'b1;
        mode_next      = M_IDLE;
      end
      tdo_pkg::CMD_CLEAR: begin
        pin_level_next = 1'b0;
        mode_next      = M_IDLE;
      end
      tdo_pkg::CMD_TOGGLE: begin
        pin_level_next = ~pin_level;
        mode_next      = M_IDLE;
      end
      tdo_pkg::CMD_PULSE: begin
        // level only inverts when nothing timed is pending
        if (mode == M_IDLE) begin
          pin_level_next = ~pin_level;
        end
        pulse_deadline_next = now_t + pls_t;
        mode_next           = M_PULSE;
      end
      tdo_pkg::CMD_DSET: begin
        delay_deadline_next = delay_end;
        mode_next           = M_DSET;
      end
      tdo_pkg::CMD_DCLEAR: begin
        delay_deadline_next = delay_end;
        mode_next           = M_DCLR;
      end
      tdo_pkg::CMD_DTOGGLE: begin
        delay_deadline_next = delay_end;
        mode_next           = M_DTOG;
      end
      tdo_pkg::CMD_DPULSE: begin
        delay_deadline_next = delay_end;
        pulse_deadline_next = delay_end + pls_t;
        mode_next           = M_DPUL;
      end
      default: ;
    endcase
  end

  assign result.level   = pin_level_next;
  assign result.changed = pin_level_next ^ pin_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_level      <= 1'b0;
      mode           <= M_IDLE;
      pulse_deadline <= '0;
      delay_deadline <= '0;
    end else if (cfg_we) begin
      pin_level <= cfg_level;
    end else if (fire) begin
      pin_level      <= pin_level_next;
      mode           <= mode_next;
      pulse_deadline <= pulse_deadline_next;
      delay_deadline <= delay_deadline_next;
    end
  end

`ifndef SYNTHESIS
  a_changed_flips: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && result.changed |=> pin_level != $past(pin_level))
    else $error("changed set but pin level held");

  a_unchanged_holds: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && !result.changed |=> pin_level == $past(pin_level))
    else $error("pin level moved without changed");

  a_dpulse_arms: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && item.command == tdo_pkg::CMD_DPULSE |=> mode == M_DPUL)
    else $error("delayed pulse did not arm");
`endif

endmodule

### src/timed_digital_output.sv
// Top level of the timed digital output: request register, control core,
// result register. Depends on tdo_pkg and tdo_ctrl.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_data) takes one command per
//   request: tick, set, clear, toggle, pulse or their delayed forms, with
//   the current time and the delay and pulse lengths.
//   res channel (res_valid / res_stall / res_data) returns exactly one
//   result per request: the pin level after it and a changed flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the pin level
//   directly; it is ready only while no request sits in the input register.
// Timing: the result of a request is registered when it leaves the input register.
//   One request per cycle is sustained unless res_stall holds; the pin
//   state update is a single add and compare on the deadline registers.
// Reset (rst, synchronous): pin low, no timed action pending, deadlines 0,
//   both registers empty.
// Stall: while res_stall holds a full result register, the input register
//   keeps its request and cmd_stall rises once it is occupied.
module timed_digital_output #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tdo_pkg::cmd_t cmd_data,
  output logic          res_valid,
  input  logic          res_stall,
  output tdo_pkg::res_t res_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  logic          item_valid;
  tdo_pkg::cmd_t item;
  logic          fire;
  logic          accept;
  logic          cfg_we;
  tdo_pkg::res_t result;

  assign fire      = item_valid && (!res_valid || !res_stall);
  assign cmd_stall = item_valid && !fire;
  assign accept    = cmd_valid && !cmd_stall;
  assign cfg_ready = !item_valid;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd_data;
    end
  end

  tdo_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_level (cfg_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall && item_valid)
    else $error("input stalled with free result register");

  a_request_moves_on: assert property (@(posedge clk) disable iff (rst)
    item_valid && !res_valid |=> res_valid)
    else $error("request did not reach result register");

  a_no_cfg_with_request: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !fire)
    else $error("config write collided with a request");
`endif

endmodule

### bench/pin_checker.sv
`timescale 1ns / 1ps
// Result checker for timed_digital_output: tracks the pin state from accepted
// requests and config writes, compares each result in order. Depends on tdo_pkg.
module pin_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  tdo_pkg::cmd_t cmd_data,
  input  logic          res_valid,
  input  logic          res_stall,
  input  tdo_pkg::res_t res_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic          cfg_data,
  output int            errors,
  output int            pending
);

  typedef enum logic [2:0] {
    PIN_IDLE, PIN_PULSE, PIN_WAIT_SET, PIN_WAIT_CLEAR, PIN_WAIT_TOGGLE, PIN_WAIT_PULSE
  } pin_mode_t;

  logic                             pin;
  pin_mode_t                        mode;
  logic [tdo_pkg::TIME_IN_BITS-1:0] pulse_end;
  logic [tdo_pkg::TIME_IN_BITS-1:0] delay_end;
  tdo_pkg::res_t                    level_q[$];

  function automatic logic write_pin(logic v);
    logic chg;
    chg = (v != pin);
    pin = v;
    return chg;
  endfunction

  // deadline passed once (now - end) is non-negative as a signed value
  function automatic logic reached(logic [tdo_pkg::TIME_IN_BITS-1:0] now,
                                   logic [tdo_pkg::TIME_IN_BITS-1:0] t_end);
    logic [tdo_pkg::TIME_IN_BITS-1:0] diff;
    diff = now - t_end;
    return !diff[tdo_pkg::TIME_IN_BITS-1];
  endfunction

  function automatic tdo_pkg::res_t pin_after(tdo_pkg::cmd_t r);
    tdo_pkg::res_t o;
    logic chg;
    chg = 1'b0;
    case (r.command)
      tdo_pkg::CMD_TICK: begin
        if (mode != PIN_IDLE &&
            reached(r.now_time, (mode == PIN_PULSE) ? pulse_end : delay_end)) begin
          case (mode)
            PIN_WAIT_SET: begin
              chg = write_pin(1'b1);
              mode = PIN_IDLE;
            end
            PIN_WAIT_CLEAR: begin
              chg = write_pin(1'b0);
              mode = PIN_IDLE;
            end
            PIN_WAIT_PULSE: begin
              chg = write_pin(!pin);
              mode = PIN_PULSE;
            end
            default: begin
              chg = write_pin(!pin);
              mode = PIN_IDLE;
            end
          endcase
        end
      end
      tdo_pkg::CMD_SET: begin
        chg = write_pin(1'b1);
        mode = PIN_IDLE;
      end
      tdo_pkg::CMD_CLEAR: begin
        chg = write_pin(1'b0);
        mode = PIN_IDLE;
      end
      tdo_pkg::CMD_TOGGLE: begin
        chg = write_pin(!pin);
        mode = PIN_IDLE;
      end
      tdo_pkg::CMD_PULSE: begin
        // a pulse only inverts when nothing timed is pending
        if (mode == PIN_IDLE) chg = write_pin(!pin);
        pulse_end = r.now_time + r.pulse_ticks;
        mode = PIN_PULSE;
      end
      tdo_pkg::CMD_DSET: begin
        delay_end = r.now_time + r.delay_ticks;
        mode = PIN_WAIT_SET;
      end
      tdo_pkg::CMD_DCLEAR: begin
        delay_end = r.now_time + r.delay_ticks;
        mode = PIN_WAIT_CLEAR;
      end
      tdo_pkg::CMD_DTOGGLE: begin
        delay_end = r.now_time + r.delay_ticks;
        mode = PIN_WAIT_TOGGLE;
      end
      tdo_pkg::CMD_DPULSE: begin
        delay_end = r.now_time + r.delay_ticks;
        pulse_end = r.now_time + r.delay_ticks + r.pulse_ticks;
        mode = PIN_WAIT_PULSE;
      end
      default: ;
    endcase
    o.level = pin;
    o.changed = chg;
    return o;
  endfunction

  always @(posedge clk) begin
    tdo_pkg::res_t want;
    if (rst) begin
      pin = 1'b0;
      mode = PIN_IDLE;
      pulse_end = '0;
      delay_end = '0;
      level_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) pin = cfg_data;
      if (res_valid && !res_stall) begin
        if (level_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request pending: level %0b changed %0b",
                     $time, res_data.level, res_data.changed);
        end else begin
          want = level_q.pop_front();
          if (res_data.level !== want.level || res_data.changed !== want.changed) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: level exp %0b got %0b, changed exp %0b got %0b",
                       $time, want.level, res_data.level, want.changed, res_data.changed);
          end
        end
      end
      if (cmd_valid && !cmd_stall) level_q.push_back(pin_after(cmd_data));
    end
    pending = level_q.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the timed_digital_output bench: clock, reset, request stimulus,
// result stalls, watchdog and verdict. Depends on tdo_pkg, timed_digital_output and pin_checker.
module tb;

  localparam int QUIET_LIMIT     = 500;
  localparam int ITEMS_PER_PHASE = 175;
  localparam logic [tdo_pkg::CMD_BITS-1:0] CMD_UNUSED = 4'hF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  tdo_pkg::cmd_t cmd_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  tdo_pkg::res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  int   errors;
  int   pending;
  int   quiet = 0;
  int   issued = 0;
  bit   calm = 1'b0;
  logic [tdo_pkg::TIME_IN_BITS-1:0] t_now = '0;

  always #5 clk = ~clk;

  timed_digital_output dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pin_checker u_check (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  task automatic put(logic [tdo_pkg::CMD_BITS-1:0] op,
                     logic [tdo_pkg::TIME_IN_BITS-1:0] now,
                     logic [tdo_pkg::TIME_IN_BITS-1:0] dly,
                     logic [tdo_pkg::TIME_IN_BITS-1:0] pls);
    cmd_data <= tdo_pkg::cmd_t'{op, now, dly, pls};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (op <= tdo_pkg::CMD_DPULSE) issued++;
    if (!calm && $urandom_range(0, 99) < 23) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 23) @(posedge clk);
    end
  endtask

  // stop requests and wait for every result to come back
  task automatic settle();
    cmd_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_level(logic v);
    settle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [tdo_pkg::CMD_BITS-1:0] timed_op();
    case ($urandom_range(0, 4))
      0:       return tdo_pkg::CMD_PULSE;
      1:       return tdo_pkg::CMD_DSET;
      2:       return tdo_pkg::CMD_DCLEAR;
      3:       return tdo_pkg::CMD_DTOGGLE;
      default: return tdo_pkg::CMD_DPULSE;
    endcase
  endfunction

  function automatic logic [tdo_pkg::CMD_BITS-1:0] direct_op();
    case ($urandom_range(0, 3))
      0:       return tdo_pkg::CMD_SET;
      1:       return tdo_pkg::CMD_CLEAR;
      2:       return tdo_pkg::CMD_TOGGLE;
      default: return tdo_pkg::CMD_PULSE;
    endcase
  endfunction

  // arm a timed action, then tick time forward toward its deadlines
  task automatic timed_burst();
    logic [tdo_pkg::TIME_IN_BITS-1:0] dly;
    logic [tdo_pkg::TIME_IN_BITS-1:0] pls;
    int n;
    if ($urandom_range(0, 5) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 24);
    else t_now += $urandom_range(0, 60);
    dly = $urandom_range(0, 12);
    pls = $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) dly = 32'h7FFF_FFF0 + $urandom_range(0, 31);
    if ($urandom_range(0, 9) == 0) pls = 32'h7FFF_FFF0 + $urandom_range(0, 31);
    put(timed_op(), t_now, dly, pls);
    n = $urandom_range(3, 14);
    repeat (n) begin
      t_now += $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) put(direct_op(), t_now, $urandom, $urandom_range(0, 8));
      else put(tdo_pkg::CMD_TICK, t_now, $urandom, $urandom);
    end
  endtask

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_level(1'b1);

    put(tdo_pkg::CMD_TICK, 0, 0, 0);
    put(tdo_pkg::CMD_SET, 1, 0, 0);          // already high
    put(tdo_pkg::CMD_CLEAR, 2, 0, 0);
    put(tdo_pkg::CMD_CLEAR, 3, 0, 0);        // already low
    put(tdo_pkg::CMD_TOGGLE, 4, 0, 0);
    put(tdo_pkg::CMD_TOGGLE, 5, 0, 0);
    put(tdo_pkg::CMD_PULSE, 100, 0, 5);
    put(tdo_pkg::CMD_TICK, 104, 0, 0);
    put(tdo_pkg::CMD_TICK, 105, 0, 0);
    put(tdo_pkg::CMD_DSET, 200, 10, 0);
    put(tdo_pkg::CMD_PULSE, 201, 0, 3);      // busy, so no inversion
    put(tdo_pkg::CMD_TICK, 204, 0, 0);
    put(tdo_pkg::CMD_DPULSE, 32'hFFFF_FFFE, 3, 2);
    put(tdo_pkg::CMD_TICK, 32'hFFFF_FFFF, 0, 0);
    put(tdo_pkg::CMD_TICK, 1, 0, 0);
    put(tdo_pkg::CMD_TICK, 3, 0, 0);
    put(tdo_pkg::CMD_DCLEAR, 50, 0, 0);
    put(tdo_pkg::CMD_TICK, 50, 0, 0);
    put(tdo_pkg::CMD_DTOGGLE, 7, 32'h8000_0000, 0);
    put(tdo_pkg::CMD_TICK, 7, 0, 0);         // half range away: not yet due
    put(tdo_pkg::CMD_TICK, 32'h8000_0007, 0, 0);
    put(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put(tdo_pkg::CMD_PULSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put(tdo_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 4; ph++) begin
      set_level(ph == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
      calm = (ph == 2);
      phase_end = issued + ITEMS_PER_PHASE;
      while (issued < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: timed_burst();
          11, 12, 13, 14: put(direct_op(), $urandom, $urandom, $urandom_range(0, 40));
          15, 16, 17: put(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
          default: put(tdo_pkg::CMD_TICK, $urandom, $urandom, $urandom);
        endcase
      end
    end
    calm = 1'b0;

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
